[hdl/iir3_pkg.sv]
`timescale 1ns / 1ps

package iir3_pkg;

   localparam int SAMPLE_WIDTH_DEF = 24;
   localparam int COEF_WIDTH_DEF   = 32;
   localparam int ACC_WIDTH_DEF    = 48;

   localparam int NUM_COEF    = 7;
   localparam int CSR_INDEX_W = 3;
   localparam int CHUNK_W     = 16;
   localparam int STEP_W      = 3;

   // product steps, in the order the sequencer runs them
   localparam logic [STEP_W-1:0] STEP_B0 = 3'd0;
   localparam logic [STEP_W-1:0] STEP_B1 = 3'd1;
   localparam logic [STEP_W-1:0] STEP_A1 = 3'd2;
   localparam logic [STEP_W-1:0] STEP_B2 = 3'd3;
   localparam logic [STEP_W-1:0] STEP_A2 = 3'd4;
   localparam logic [STEP_W-1:0] STEP_B3 = 3'd5;
   localparam logic [STEP_W-1:0] STEP_A3 = 3'd6;

   typedef enum logic [CSR_INDEX_W-1:0] {
      COEF_B0 = 3'd0,
      COEF_B1 = 3'd1,
      COEF_B2 = 3'd2,
      COEF_B3 = 3'd3,
      COEF_A1 = 3'd4,
      COEF_A2 = 3'd5,
      COEF_A3 = 3'd6
   } coef_idx_type;

   typedef enum logic [1:0] {
      TERM_NONE,
      TERM_ADD_FF,
      TERM_SUB_FB
   } term_op_type;

   typedef enum logic [1:0] {
      SRC_D1,
      SRC_D2,
      SRC_D3,
      SRC_ZERO
   } acc_src_type;

   typedef enum logic [1:0] {
      DST_Y,
      DST_D1,
      DST_D2,
      DST_D3
   } acc_dst_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DRAIN1,
      ST_DRAIN2,
      ST_STORE,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic         mul_en;
      logic         mul_first;
      logic         mul_sel_y;
      coef_idx_type coef_sel;
      term_op_type  term_op;
      logic         acc_load;
      acc_src_type  load_sel;
      logic         store_en;
      acc_dst_type  store_sel;
      logic         x_load;
      logic         out_load;
   } dp_cmd_type;

   function automatic coef_idx_type step_coef(input logic [STEP_W-1:0] step);
      coef_idx_type c;
      case (step)
         STEP_B0: c = COEF_B0;
         STEP_B1: c = COEF_B1;
         STEP_A1: c = COEF_A1;
         STEP_B2: c = COEF_B2;
         STEP_A2: c = COEF_A2;
         STEP_B3: c = COEF_B3;
         default: c = COEF_A3;
      endcase
      return c;
   endfunction

   function automatic logic step_uses_y(input logic [STEP_W-1:0] step);
      return (step == STEP_A1) || (step == STEP_A2) || (step == STEP_A3);
   endfunction

endpackage

[hdl/iir3_ctrl.sv]
`timescale 1ns / 1ps

module iir3_ctrl
   import iir3_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int ACC_WIDTH    = ACC_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output dp_cmd_type cmd
);

   localparam int NX    = (SAMPLE_WIDTH + CHUNK_W - 1) / CHUNK_W;
   localparam int NY    = (ACC_WIDTH + CHUNK_W - 1) / CHUNK_W;
   localparam int CNT_W = (NY > 1) ? $clog2(NY) : 1;
   localparam logic [CNT_W-1:0] X_LAST = CNT_W'(NX - 1);
   localparam logic [CNT_W-1:0] Y_LAST = CNT_W'(NY - 1);

   ctrl_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_B0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      logic uses_y;
      logic last;
      uses_y       = step_uses_y(step_ff);
      last         = (cnt_ff == (uses_y ? Y_LAST : X_LAST));
      state_in     = state_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.x_load   = 1'b1;
               cmd.acc_load = 1'b1;
               cmd.load_sel = SRC_D1;
               step_in      = STEP_B0;
               cnt_in       = '0;
               state_in     = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_first = (cnt_ff == '0);
            cmd.mul_sel_y = uses_y;
            cmd.coef_sel  = step_coef(step_ff);
            if (last) begin
               cmd.term_op = uses_y ? TERM_SUB_FB : TERM_ADD_FF;
               cnt_in      = '0;
               // even steps close a sum
               if (!step_ff[0]) begin
                  state_in = ST_DRAIN1;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN1: begin
            state_in = ST_DRAIN2;
         end
         ST_DRAIN2: begin
            state_in = ST_STORE;
         end
         ST_STORE: begin
            cmd.store_en = 1'b1;
            step_in      = step_ff + 1'b1;
            state_in     = ST_MUL;
            case (step_ff)
               STEP_B0: begin
                  cmd.store_sel = DST_Y;
                  cmd.acc_load  = 1'b1;
                  cmd.load_sel  = SRC_D2;
               end
               STEP_A1: begin
                  cmd.store_sel = DST_D1;
                  cmd.acc_load  = 1'b1;
                  cmd.load_sel  = SRC_D3;
               end
               STEP_A2: begin
                  cmd.store_sel = DST_D2;
                  cmd.acc_load  = 1'b1;
                  cmd.load_sel  = SRC_ZERO;
               end
               default: begin
                  cmd.store_sel = DST_D3;
                  step_in       = STEP_B0;
                  state_in      = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

[hdl/iir3_dp.sv]
`timescale 1ns / 1ps

module iir3_dp
   import iir3_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int COEF_WIDTH   = COEF_WIDTH_DEF,
   parameter int ACC_WIDTH    = ACC_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  dp_cmd_type                     cmd,
   input  logic                           csr_valid,
   input  logic [CSR_INDEX_W-1:0]         csr_index,
   input  logic [COEF_WIDTH-1:0]          csr_data,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                           req_last,
   output logic signed [SAMPLE_WIDTH-1:0] out_sample,
   output logic                           out_last
);

   localparam int SF      = SAMPLE_WIDTH - 1;
   localparam int CF      = COEF_WIDTH - 4;
   localparam int AF      = ACC_WIDTH - 8;
   localparam int NX      = (SAMPLE_WIDTH + CHUNK_W - 1) / CHUNK_W;
   localparam int NY      = (ACC_WIDTH + CHUNK_W - 1) / CHUNK_W;
   localparam int OPW     = NY * CHUNK_W;
   localparam int XPAD    = OPW - NX * CHUNK_W;
   localparam int PPW     = CHUNK_W + 1 + COEF_WIDTH;
   localparam int PROD_W  = ACC_WIDTH + COEF_WIDTH;
   localparam int TW      = PROD_W + 1;
   localparam int SUM_W   = ACC_WIDTH + 8;
   localparam int FF_FROM = SF + CF;
   localparam int FF_RSH  = (FF_FROM > AF) ? FF_FROM - AF : 0;
   localparam int FF_LSH  = (AF > FF_FROM) ? AF - FF_FROM : 0;
   localparam int O_RSH   = (AF > SF) ? AF - SF : 0;
   localparam int O_LSH   = (SF > AF) ? SF - AF : 0;
   localparam int OW      = ACC_WIDTH + 1 + O_LSH;

   localparam logic signed [TW-1:0] FF_RND = (TW'(1) << FF_RSH) >> 1;
   localparam logic signed [TW-1:0] FB_RND = (TW'(1) << CF) >> 1;
   localparam logic signed [OW-1:0] O_RND  = (OW'(1) << O_RSH) >> 1;
   localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << CF;

   logic signed [SAMPLE_WIDTH-1:0] x_ff;
   logic                           blk_ff;
   logic signed [COEF_WIDTH-1:0]   coef_ff [NUM_COEF];
   logic signed [ACC_WIDTH-1:0]    y_ff, d1_ff, d2_ff, d3_ff;
   logic signed [SUM_W-1:0]        acc_ff, acc_in;
   logic signed [OPW-1:0]          x_op, y_op;
   logic [OPW-1:0]                 opnd_ff, opnd_src;
   logic [CHUNK_W-1:0]             chunk;
   logic                           chunk_msb;
   logic signed [PPW-1:0]          pp_ff, pp_in;
   logic                           pp_vld_ff, pp_first_ff;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   term_op_type                    op1_ff, op2_ff;
   logic signed [TW-1:0]           prod_w, t_ff_w, t_fb_w;
   logic signed [SUM_W-1:0]        term_ff, term_fb;
   logic [SUM_W-ACC_WIDTH:0]       acc_hi;
   logic signed [ACC_WIDTH-1:0]    acc_sat;
   logic signed [OW-1:0]           o_w, o_t;
   logic [OW-SAMPLE_WIDTH:0]       o_hi;
   logic signed [SAMPLE_WIDTH-1:0] o_sat;
   logic signed [SAMPLE_WIDTH-1:0] out_sample_ff;
   logic                           out_last_ff;

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEF; i++) begin
            coef_ff[i] <= (i == int'(COEF_B0)) ? COEF_ONE : '0;
         end
      end else if (csr_valid && (csr_index < CSR_INDEX_W'(NUM_COEF))) begin
         coef_ff[csr_index] <= csr_data;
      end
   end

   // shared multiplier, one chunk of the operand per cycle, top chunk first
   assign x_op      = OPW'(x_ff);
   assign y_op      = OPW'(y_ff);
   assign opnd_src  = cmd.mul_first ? (cmd.mul_sel_y ? y_op : (x_op << XPAD)) : opnd_ff;
   assign chunk     = opnd_src[OPW-1 -: CHUNK_W];
   assign chunk_msb = cmd.mul_first & chunk[CHUNK_W-1];
   assign pp_in     = $signed({chunk_msb, chunk}) * coef_ff[cmd.coef_sel];

   assign prod_in = pp_first_ff ? PROD_W'(pp_ff) : (prod_ff <<< CHUNK_W) + PROD_W'(pp_ff);

   // bring product to accumulator format, round half up
   assign prod_w  = TW'(prod_ff);
   assign t_ff_w  = ((prod_w <<< FF_LSH) + FF_RND) >>> FF_RSH;
   assign t_fb_w  = (prod_w + FB_RND) >>> CF;
   assign term_ff = $signed(t_ff_w[SUM_W-1:0]);
   assign term_fb = $signed(t_fb_w[SUM_W-1:0]);

   always_comb begin
      acc_in = acc_ff;
      case (op2_ff)
         TERM_ADD_FF: acc_in = acc_ff + term_ff;
         TERM_SUB_FB: acc_in = acc_ff - term_fb;
         default:     acc_in = acc_ff;
      endcase
      if (cmd.acc_load) begin
         case (cmd.load_sel)
            SRC_D1:  acc_in = SUM_W'(d1_ff);
            SRC_D2:  acc_in = SUM_W'(d2_ff);
            SRC_D3:  acc_in = SUM_W'(d3_ff);
            default: acc_in = '0;
         endcase
      end
   end

   assign acc_hi  = acc_ff[SUM_W-1:ACC_WIDTH-1];
   assign acc_sat = ((&acc_hi) || !(|acc_hi)) ? acc_ff[ACC_WIDTH-1:0] :
                    acc_ff[SUM_W-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}} :
                                      {1'b0, {(ACC_WIDTH-1){1'b1}}};

   // output rounding and clamp
   assign o_w   = OW'(y_ff);
   assign o_t   = ((o_w <<< O_LSH) + O_RND) >>> O_RSH;
   assign o_hi  = o_t[OW-1:SAMPLE_WIDTH-1];
   assign o_sat = ((&o_hi) || !(|o_hi)) ? o_t[SAMPLE_WIDTH-1:0] :
                  o_t[OW-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}} :
                              {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_vld_ff <= 1'b0;
         op1_ff    <= TERM_NONE;
         op2_ff    <= TERM_NONE;
      end else begin
         pp_vld_ff <= cmd.mul_en;
         op1_ff    <= cmd.term_op;
         op2_ff    <= op1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff <= '0;
         d2_ff <= '0;
         d3_ff <= '0;
      end else if (cmd.store_en) begin
         case (cmd.store_sel)
            DST_D1:  d1_ff <= acc_sat;
            DST_D2:  d2_ff <= acc_sat;
            DST_D3:  d3_ff <= acc_sat;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.x_load) begin
         x_ff   <= req_sample;
         blk_ff <= req_last;
      end
      if (cmd.mul_en) begin
         pp_ff       <= pp_in;
         pp_first_ff <= cmd.mul_first;
         opnd_ff     <= opnd_src << CHUNK_W;
      end
      if (pp_vld_ff) begin
         prod_ff <= prod_in;
      end
      if (cmd.store_en && (cmd.store_sel == DST_Y)) begin
         y_ff <= acc_sat;
      end
      if (cmd.out_load) begin
         out_sample_ff <= o_sat;
         out_last_ff   <= blk_ff;
      end
      acc_ff <= acc_in;
   end

   assign out_sample = out_sample_ff;
   assign out_last   = out_last_ff;

endmodule

[hdl/third_order_iir_filter.sv]
`timescale 1ns / 1ps

// Third-order IIR filter, transposed direct form II, one Q1.23 sample in and one
// saturated Q1.23 sample out per request; tlast passes through. Seven Q4.28
// coefficients (b0..b3, a1..a3) are written over the csr channel at index 0..6
// and should only be changed while no request is in flight. All seven products
// go through one shared signed multiplier that takes 16 bits of the sample or
// accumulator operand per cycle, so a request's work grows with the number of
// 16-bit chunks in the sample (sample products) and in the accumulator (feedback
// products), plus pipeline drain and store steps. A finished result sits in an
// output register, so the next request is taken while it waits.
module third_order_iir_filter
   import iir3_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int COEF_WIDTH   = COEF_WIDTH_DEF,
   parameter int ACC_WIDTH    = ACC_WIDTH_DEF,
   localparam int TDATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [TDATA_W-1:0]     req_tdata,   // sample_in
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [TDATA_W-1:0]     rsp_tdata,   // sample_out
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COEF_WIDTH-1:0]  csr_data
);

   dp_cmd_type                     cmd;
   logic signed [SAMPLE_WIDTH-1:0] out_sample;

   iir3_ctrl #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .ACC_WIDTH   (ACC_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .cmd       (cmd)
   );

   iir3_dp #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .COEF_WIDTH  (COEF_WIDTH),
      .ACC_WIDTH   (ACC_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_sample($signed(req_tdata[SAMPLE_WIDTH-1:0])),
      .req_last  (req_tlast),
      .out_sample(out_sample),
      .out_last  (rsp_tlast)
   );

   assign csr_ready = 1'b1;
   assign rsp_tdata = TDATA_W'($unsigned(out_sample));

   // one request at a time
   a_req_one_at_a_time: assert property (
      @(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready
   ) else $error("request taken while previous one in progress");

   // a new result is only presented after the sequencer finished its run
   a_rsp_after_run: assert property (
      @(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready)
   ) else $error("result presented without a completed run");

   // nothing is multiplied while the block waits for a request
   a_idle_quiet: assert property (
      @(posedge clock) disable iff (reset)
      req_tready |-> !cmd.mul_en && !cmd.store_en && !cmd.out_load
   ) else $error("datapath active while idle");

endmodule
